### hw/rtl/utf8_bmp_decoder_core_defines.svh
// Assertion macros shared by the decoder's RTL files.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef UTF8_BMP_DECODER_CORE_DEFINES_SVH
`define UTF8_BMP_DECODER_CORE_DEFINES_SVH

// Checks a property while the block is out of reset.
`define UTF8BD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property at every clock edge, reset included.
`define UTF8BD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/utf8bd_pkg.sv
package utf8bd_pkg;

  // Field widths.
  localparam int ByteW = 8;
  localparam int CpW   = 16;

  // Byte classes.
  localparam logic [ByteW-1:0] CtrlLimit   = 8'h20;
  localparam logic [ByteW-1:0] AsciiLimit  = 8'h80;
  localparam logic [ByteW-1:0] LeadTwoLo   = 8'hC2;
  localparam logic [ByteW-1:0] LeadTwoHi   = 8'hDF;
  localparam logic [ByteW-1:0] LeadThreeLo = 8'hE0;
  localparam logic [ByteW-1:0] LeadThreeHi = 8'hEF;
  localparam logic [ByteW-1:0] LeadFourLo  = 8'hF0;
  localparam logic [ByteW-1:0] LeadFourHi  = 8'hF4;
  localparam logic [ByteW-1:0] ContMask    = 8'hC0;
  localparam logic [ByteW-1:0] ContTag     = 8'h80;

  // Code point limits.
  localparam logic [CpW-1:0] Replacement = 16'hFFFD;
  localparam logic [CpW-1:0] MinThree    = 16'h0800;
  localparam logic [CpW-1:0] SurrLo      = 16'hD800;
  localparam logic [CpW-1:0] SurrHi      = 16'hDFFF;

  // Continuation bytes that a pending sequence needs in all.
  localparam logic [1:0] ExpNone  = 2'd0;
  localparam logic [1:0] ExpTwo   = 2'd1;
  localparam logic [1:0] ExpThree = 2'd2;
  localparam logic [1:0] ExpFour  = 2'd3;

  // Queue between front and back.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One queue entry: all results but the last are replacements.
  typedef struct packed {
    logic [1:0]     last_idx;  // number of results minus one
    logic [CpW-1:0] cp;        // code point of the last result
    logic           eot;       // byte closed the text
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t data;
  } qslot_t;

endpackage

### hw/rtl/utf8bd_byte_if.sv
interface utf8bd_byte_if import utf8bd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

### hw/rtl/utf8bd_cp_if.sv
interface utf8bd_cp_if import utf8bd_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           run_last;
  logic           text_done;

  modport source (output valid, output code_point, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input code_point, input run_last, input text_done,
                  output ready);
endinterface

### hw/rtl/utf8bd_front.sv
`include "utf8_bmp_decoder_core_defines.svh"

module utf8bd_front import utf8bd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8bd_byte_if.sink   byte_i,
  input  logic          full_i,
  output qslot_t        push_o
);

  logic [1:0]       exp_q, exp_d;
  logic [1:0]       taken_q, taken_d;
  logic [CpW-1:0]   acc_q, acc_d;

  logic             accept;
  logic [ByteW-1:0] b;
  logic             eot;
  logic             is_cont;
  logic [CpW-1:0]   acc_ext;
  logic [1:0]       taken_inc;
  logic             bad_seq;

  logic             st_res;
  logic [CpW-1:0]   st_cp;
  logic [1:0]       st_exp;
  logic [CpW-1:0]   st_acc;

  logic             has_res;
  logic [1:0]       n_m1;
  logic [CpW-1:0]   cp;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.in_byte;
  assign eot          = byte_i.end_of_text;

  // Continuation test and the code point extended by this byte.
  assign is_cont   = (b & ContMask) == ContTag;
  assign acc_ext   = {acc_q[CpW-7:0], b[5:0]};
  assign taken_inc = taken_q + 2'd1;
  assign bad_seq   = (exp_q == ExpThree && acc_ext < MinThree) ||
                     (acc_ext >= SurrLo && acc_ext <= SurrHi) ||
                     (exp_q == ExpFour);

  // Classification of a byte seen with no sequence pending.
  always_comb begin
    st_res = 1'b1;
    st_cp  = Replacement;
    st_exp = ExpNone;
    st_acc = '0;
    priority if (b < AsciiLimit) begin
      st_cp = (b < CtrlLimit) ? Replacement : {{(CpW-ByteW){1'b0}}, b};
    end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
      st_res = 1'b0;
      st_exp = ExpTwo;
      st_acc = {{(CpW-5){1'b0}}, b[4:0]};
    end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
      st_res = 1'b0;
      st_exp = ExpThree;
      st_acc = {{(CpW-4){1'b0}}, b[3:0]};
    end else if (b >= LeadFourLo && b <= LeadFourHi) begin
      st_res = 1'b0;
      st_exp = ExpFour;
      st_acc = {{(CpW-3){1'b0}}, b[2:0]};
    end else begin
      st_cp = Replacement;
    end
  end

  // Sequence tracking: how many results this byte causes and the last one.
  always_comb begin
    has_res = 1'b0;
    n_m1    = 2'd0;
    cp      = Replacement;
    exp_d   = exp_q;
    taken_d = taken_q;
    acc_d   = acc_q;
    if (exp_q != ExpNone) begin
      if (is_cont) begin
        if (taken_inc == exp_q) begin
          // Sequence complete.
          has_res = 1'b1;
          cp      = bad_seq ? Replacement : acc_ext;
          exp_d   = ExpNone;
          taken_d = 2'd0;
          acc_d   = '0;
        end else if (eot) begin
          // Unfinished at the end: one replacement per byte taken.
          has_res = 1'b1;
          n_m1    = taken_inc;
          exp_d   = ExpNone;
          taken_d = 2'd0;
          acc_d   = '0;
        end else begin
          taken_d = taken_inc;
          acc_d   = acc_ext;
        end
      end else begin
        // Broken sequence: flush it, then decode this byte afresh.
        has_res = 1'b1;
        if (st_res) begin
          n_m1    = taken_inc;
          cp      = st_cp;
          exp_d   = ExpNone;
          taken_d = 2'd0;
          acc_d   = '0;
        end else if (eot) begin
          n_m1    = taken_inc;
          exp_d   = ExpNone;
          taken_d = 2'd0;
          acc_d   = '0;
        end else begin
          n_m1    = taken_q;
          exp_d   = st_exp;
          taken_d = 2'd0;
          acc_d   = st_acc;
        end
      end
    end else begin
      if (st_res) begin
        has_res = 1'b1;
        cp      = st_cp;
      end else if (eot) begin
        // A lead byte that closes the text is flushed at once.
        has_res = 1'b1;
      end else begin
        exp_d   = st_exp;
        taken_d = 2'd0;
        acc_d   = st_acc;
      end
    end
  end

  // Queue write for bytes that cause at least one result.
  always_comb begin
    push_o.valid         = accept && has_res;
    push_o.data.last_idx = n_m1;
    push_o.data.cp       = cp;
    push_o.data.eot      = eot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= ExpNone;
      taken_q <= 2'd0;
      acc_q   <= '0;
    end else if (accept) begin
      exp_q   <= exp_d;
      taken_q <= taken_d;
      acc_q   <= acc_d;
    end
  end

  `UTF8BD_ASSERT(a_taken_below_exp,
                 (exp_q == ExpNone) || (taken_q < exp_q),
                 "continuation count ran past sequence length")
  `UTF8BD_ASSERT(a_eot_clears,
                 (accept && eot) |=> (exp_q == ExpNone && taken_q == 2'd0),
                 "sequence still pending after end of text")

endmodule

### hw/rtl/utf8bd_queue.sv
`include "utf8_bmp_decoder_core_defines.svh"

module utf8bd_queue import utf8bd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qslot_t push_i,
  output logic   full_o,
  output qslot_t head_o,
  input  logic   pop_i
);

  qentry_t          mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;

  assign full_o      = count_q == QCntW'(QDepth);
  assign do_push     = push_i.valid && !full_o;
  assign head_o.valid = count_q != '0;
  assign head_o.data  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAw'(1);
      end
      count_q <= count_q + QCntW'(do_push) - QCntW'(pop_i);
    end
  end

  `UTF8BD_ASSERT(a_count_bound, count_q <= QCntW'(QDepth),
                 "queue fill count exceeds depth")
  `UTF8BD_ASSERT(a_no_pop_empty, pop_i |-> (count_q != '0),
                 "pop from an empty queue")

endmodule

### hw/rtl/utf8bd_back.sv
`include "utf8_bmp_decoder_core_defines.svh"

module utf8bd_back import utf8bd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qslot_t        head_i,
  output logic          pop_o,
  utf8bd_cp_if.source   cp_o
);

  logic [1:0] idx_q;
  logic       is_last;
  logic       out_acc;

  // Expand the head entry into its results, the last one carrying the code point.
  assign is_last       = idx_q == head_i.data.last_idx;
  assign out_acc       = cp_o.valid && cp_o.ready;
  assign pop_o         = out_acc && is_last;
  assign cp_o.valid    = head_i.valid;
  assign cp_o.code_point = is_last ? head_i.data.cp : Replacement;
  assign cp_o.run_last = is_last;
  assign cp_o.text_done = is_last && head_i.data.eot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (out_acc) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  `UTF8BD_ASSERT(a_idx_in_entry, head_i.valid |-> (idx_q <= head_i.data.last_idx), "result index ran past the entry")

endmodule

### hw/rtl/utf8_bmp_decoder_core.sv
// UTF-8 decoder for Basic Multilingual Plane text: takes one byte word per
// cycle while the queue is not full, with an end-of-text flag, and delivers
// code point words, U+FFFD for control bytes, stray bytes, broken or
// unfinished sequences, overlong three-byte forms, surrogates and every
// four-byte form. A byte causes zero to four words; the last one is marked
// run_last, and on the final byte of the text also text_done. The front
// classifies each byte combinationally and writes one entry per producing
// byte into a four-entry queue; the back expands the head entry, one output
// word per cycle while the receiver is ready. Input runs at one byte per
// cycle while bytes yield at most one word each and the receiver keeps up;
// otherwise entries build up and the input stalls only once the queue is full.
module utf8_bmp_decoder_core import utf8bd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8bd_byte_if.sink   byte_i,
  utf8bd_cp_if.source   cp_o
);

  qslot_t push;
  qslot_t head;
  logic   full;
  logic   pop;

  utf8bd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push)
  );

  utf8bd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  utf8bd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cp_o   (cp_o)
  );

endmodule

### tb/sv/utf8_bmp_decoder_core_tb.sv
`timescale 1ns / 100ps

module utf8_bmp_decoder_core_tb;
  import utf8bd_pkg::*;

  localparam int RandItems   = 145;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 60;
  localparam int HoldAfter   = 40;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             eot;
  } text_byte_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           run_last;
    logic           text_done;
  } cp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  utf8bd_byte_if byte_if ();
  utf8bd_cp_if   cp_if ();

  utf8_bmp_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cp_o   (cp_if)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decoder state as the testbench predicts it.
  logic [20:0] acc_bits;
  logic [1:0]  seq_need;
  logic [1:0]  seq_got;

  cp_word_t    step_cps[$];
  cp_word_t    cps_owed[$];
  text_byte_t  text_bytes[$];

  int unsigned bytes_taken = 0;
  int unsigned words_seen  = 0;
  int unsigned err_count   = 0;
  int unsigned quiet_cycles = 0;
  logic        rx_hold_on;

  task automatic put_cp(input logic [CpW-1:0] cp);
    cp_word_t w;
    w = '{cp: cp, run_last: 1'b0, text_done: 1'b0};
    step_cps.insert(step_cps.size(), w);
  endtask

  task automatic clear_seq();
    acc_bits = '0;
    seq_need = ExpNone;
    seq_got  = 2'd0;
  endtask

  // A broken or unfinished sequence gives one replacement per byte taken.
  task automatic flush_seq();
    for (int i = 0; i <= seq_got; i++) put_cp(Replacement);
    clear_seq();
  endtask

  // Decode a byte with no sequence pending.
  task automatic start_byte(input logic [ByteW-1:0] b_in);
    if (b_in < AsciiLimit) begin
      put_cp((b_in < CtrlLimit) ? Replacement : {8'h00, b_in});
    end else if (b_in >= LeadTwoLo && b_in <= LeadTwoHi) begin
      acc_bits = {16'h0000, b_in[4:0]};
      seq_need = ExpTwo;
      seq_got  = 2'd0;
    end else if (b_in >= LeadThreeLo && b_in <= LeadThreeHi) begin
      acc_bits = {17'h00000, b_in[3:0]};
      seq_need = ExpThree;
      seq_got  = 2'd0;
    end else if (b_in >= LeadFourLo && b_in <= LeadFourHi) begin
      acc_bits = {18'h00000, b_in[2:0]};
      seq_need = ExpFour;
      seq_got  = 2'd0;
    end else begin
      put_cp(Replacement);
    end
  endtask

  // Works out the words that one accepted byte causes and queues them.
  task automatic decode_byte(input text_byte_t item);
    logic     bad;
    cp_word_t w;
    step_cps.delete();
    if (seq_need != ExpNone && seq_got < seq_need) begin
      if ((item.value & ContMask) == ContTag) begin
        acc_bits = {acc_bits[14:0], item.value[5:0]};
        seq_got  = seq_got + 2'd1;
        if (seq_got == seq_need) begin
          bad = (seq_need == ExpThree && acc_bits < MinThree) || (|acc_bits[20:16]) ||
                (acc_bits >= SurrLo && acc_bits <= SurrHi) || seq_need == ExpFour;
          put_cp(bad ? Replacement : acc_bits[CpW-1:0]);
          clear_seq();
        end else if (item.eot) begin
          flush_seq();
        end
      end else begin
        flush_seq();
        start_byte(item.value);
      end
    end else begin
      clear_seq();
      start_byte(item.value);
    end
    if (item.eot && seq_need != ExpNone) flush_seq();
    if (step_cps.size() > 0) begin
      w = step_cps[step_cps.size()-1];
      w.run_last  = 1'b1;
      w.text_done = item.eot;
      step_cps[step_cps.size()-1] = w;
    end
    foreach (step_cps[k]) cps_owed.insert(cps_owed.size(), step_cps[k]);
  endtask

  task automatic queue_byte(input logic [ByteW-1:0] value, input logic eot);
    text_byte_t t;
    t = '{value: value, eot: eot};
    text_bytes.insert(text_bytes.size(), t);
  endtask

  // A random byte now and then closes the text.
  task automatic queue_rand(input logic [ByteW-1:0] value);
    queue_byte(value, $urandom_range(0, 15) == 0);
  endtask

  function automatic logic [ByteW-1:0] rand_cont();
    return ContTag | 8'($urandom_range(0, 63));
  endfunction

  // Sender: bursts of random length with random gaps, no gaps while the
  // receiver holds off so that the block fills up.
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    text_byte_t item;
    text_byte_t seen;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_ni) begin
      byte_if.valid       <= 1'b0;
      byte_if.in_byte     <= '0;
      byte_if.end_of_text <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        seen = '{value: byte_if.in_byte, eot: byte_if.end_of_text};
        decode_byte(seen);
        bytes_taken <= bytes_taken + 1;
      end
      if (byte_if.valid && !byte_if.ready) begin
        // The word on offer stays until it is taken.
      end else if (gap_left != 0 && !rx_hold_on) begin
        byte_if.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (text_bytes.size() != 0) begin
        item = text_bytes.pop_front();
        byte_if.valid       <= 1'b1;
        byte_if.in_byte     <= item.value;
        byte_if.end_of_text <= item.eot;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: phases of full rate, half rate and quarter rate, and one long
  // hold-off once the output has got going.
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    int unsigned rx_mode;
    int unsigned rx_phase_left;
    int unsigned hold_left;
    logic        hold_done;
    if (!rst_ni) begin
      cp_if.ready <= 1'b0;
      rx_hold_on  <= 1'b0;
      rx_mode       = 0;
      rx_phase_left = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else if (hold_left != 0) begin
      cp_if.ready <= 1'b0;
      rx_hold_on  <= (hold_left > 1);
      hold_left = hold_left - 1;
    end else if (!hold_done && words_seen >= HoldAfter) begin
      cp_if.ready <= 1'b0;
      rx_hold_on  <= 1'b1;
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end else begin
      rx_hold_on <= 1'b0;
      if (rx_phase_left == 0) begin
        rx_mode       = $urandom_range(0, 2);
        rx_phase_left = $urandom_range(8, 48);
      end else begin
        rx_phase_left = rx_phase_left - 1;
      end
      case (rx_mode)
        0: begin
          cp_if.ready <= 1'b1;
        end
        1: begin
          cp_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          cp_if.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Each accepted word is checked against the oldest predicted word.
  always @(posedge clk_i) begin : check_words
    cp_word_t want;
    if (rst_ni && cp_if.valid && cp_if.ready) begin
      words_seen <= words_seen + 1;
      if (cps_owed.size() == 0) begin
        $display("%0t: unexpected word, expected none, got cp=%h run_last=%b text_done=%b",
                 $time, cp_if.code_point, cp_if.run_last, cp_if.text_done);
        err_count++;
      end else begin
        want = cps_owed.pop_front();
        if (cp_if.code_point !== want.cp) begin
          $display("%0t: code_point expected %h got %h", $time, want.cp, cp_if.code_point);
          err_count++;
        end
        if (cp_if.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.run_last,
                   cp_if.run_last);
          err_count++;
        end
        if (cp_if.text_done !== want.text_done) begin
          $display("%0t: text_done expected %b got %b", $time, want.text_done,
                   cp_if.text_done);
          err_count++;
        end
      end
    end
  end

  // Cycles since the last word moved on either side.
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (cp_if.valid && cp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < StallLimit) @(negedge clk_i);
    $display("utf8_bmp_decoder_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned      pick;
    int unsigned      target;
    int unsigned      nconts;
    int unsigned      total;
    logic [ByteW-1:0] lead;
    logic [ByteW-1:0] brk;

    rst_ni = 1'b0;
    clear_seq();

    // Directed text: control and stray bytes, the smallest printable byte,
    // each sequence length, overlong and surrogate forms, a four-byte form,
    // a broken four-byte sequence giving four words, and an unfinished one
    // at the end of the text.
    queue_byte(8'h00, 1'b0);
    queue_byte(CtrlLimit, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(LeadTwoLo, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(LeadThreeLo, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hED, 1'b0);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(LeadThreeHi, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(LeadFourHi, 1'b0);
    queue_byte(8'h8F, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(LeadFourLo, 1'b0);
    queue_byte(8'h90, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);

    // Random text: mostly well-formed sequences with random content, the
    // rest broken sequences and arbitrary bytes.
    target = text_bytes.size() + RandItems;
    while (text_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        queue_rand(8'($urandom_range(CtrlLimit, 8'h7F)));
      end else if (pick < 30) begin
        queue_rand(8'($urandom_range(0, 8'h1F)));
      end else if (pick < 48) begin
        queue_rand(8'($urandom_range(LeadTwoLo, LeadTwoHi)));
        queue_rand(rand_cont());
      end else if (pick < 66) begin
        queue_rand(8'($urandom_range(LeadThreeLo, LeadThreeHi)));
        queue_rand(rand_cont());
        queue_rand(rand_cont());
      end else if (pick < 74) begin
        queue_rand(8'($urandom_range(LeadFourLo, LeadFourHi)));
        queue_rand(rand_cont());
        queue_rand(rand_cont());
        queue_rand(rand_cont());
      end else if (pick < 86) begin
        // A sequence cut short by a byte that is no continuation.
        lead = 8'($urandom_range(LeadTwoLo, LeadFourHi));
        if (lead >= LeadFourLo) begin
          nconts = $urandom_range(0, 2);
        end else if (lead >= LeadThreeLo) begin
          nconts = $urandom_range(0, 1);
        end else begin
          nconts = 0;
        end
        queue_rand(lead);
        repeat (nconts) queue_rand(rand_cont());
        brk = 8'($urandom_range(0, 255));
        if ((brk & ContMask) == ContTag) brk = brk ^ 8'h40;
        queue_rand(brk);
      end else begin
        queue_rand(8'($urandom_range(0, 255)));
      end
    end
    queue_byte(8'h2E, 1'b1);
    total = text_bytes.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_taken != total || cps_owed.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (err_count == 0) begin
      $display("utf8_bmp_decoder_core_tb: clean");
    end else begin
      $display("utf8_bmp_decoder_core_tb: errors");
    end
    $finish;
  end

endmodule
